>>> hdl/mrfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_pkg
// Types, constants and the CRC-16 byte step for the reply frame parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

   typedef logic [1:0]        command_type;
   typedef logic [7:0]        byte_type;
   typedef logic [3:0]        pos_type;
   typedef logic [15:0]       crc_type;
   typedef logic signed [15:0] tenths_type;

   // commands
   localparam command_type CMD_BYTE          = 2'd0;
   localparam command_type CMD_CLEAR_SENT    = 2'd1;
   localparam command_type CMD_CLEAR_TIMEOUT = 2'd2;

   // result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_ACK   = 1'b1;

   localparam int  FRAME_DEPTH  = 13;
   localparam pos_type FRAME_LEN    = 4'd13;
   localparam pos_type CRC_LEN      = 4'd11;
   localparam pos_type TRAIL_LO_POS = 4'd11;
   localparam pos_type ECHO_LEN     = 4'd8;
   localparam pos_type PAYLOAD_LO   = 4'd7;   // bytes 3..6 are read back at 7..10
   localparam pos_type PAYLOAD_HI   = 4'd10;
   localparam pos_type PAYLOAD_LAG  = 4'd4;

   localparam byte_type HDR_FUNC  = 8'h03;
   localparam byte_type HDR_COUNT = 8'h08;
   localparam crc_type  CRC_INIT  = 16'hFFFF;
   localparam crc_type  CRC_POLY  = 16'hA001;

   // fixed write echo 08 10 00 04 00 02 00 90
   function automatic byte_type echo_byte(input logic [2:0] idx);
      byte_type b;
      case (idx)
         3'd0:    b = 8'h08;
         3'd1:    b = 8'h10;
         3'd2:    b = 8'h00;
         3'd3:    b = 8'h04;
         3'd4:    b = 8'h00;
         3'd5:    b = 8'h02;
         3'd6:    b = 8'h00;
         3'd7:    b = 8'h90;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Modbus CRC-16, reflected, one byte
   function automatic crc_type crc_feed(input crc_type crc, input byte_type b);
      crc_type c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/mrfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp interfaces
// Valid/ready channels for received words, results and the address register.
// ----------------------------------------------------------------------------
interface mrfp_req_if;
   logic                  valid;
   logic                  ready;
   mrfp_pkg::command_type command;
   mrfp_pkg::byte_type    rx_byte;
   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface mrfp_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 result_kind;
   mrfp_pkg::tenths_type angle_tenths;
   mrfp_pkg::tenths_type rate_tenths;
   modport source (output valid, output result_kind, output angle_tenths,
                   output rate_tenths, input ready);
   modport sink   (input valid, input result_kind, input angle_tenths,
                   input rate_tenths, output ready);
endinterface

interface mrfp_csr_if;
   logic               valid;
   logic               ready;
   mrfp_pkg::byte_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mrfp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/modbus_rtu_reply_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_reply_frame_parser_unit
// Parses 13-byte read replies (CRC-16 checked) and the 8-byte clear echo.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    payload
//  req_port  in   valid/ready  command, rx_byte
//  rsp_port  out  valid/ready  result_kind, angle_tenths, rate_tenths
//  csr_port  in   valid/ready  data (slave address), ready out of reset
//
//  One word per cycle; a result appears the cycle after the word that ends a
//  frame or echo. Frame bytes go to a 13x8 RAM; bytes 3..6 are read back one
//  per word while bytes 7..10 arrive. Bytes 0..10 enter the CRC one per word.
//  req_port.ready drops while a result waits and rsp_port.ready is low, and
//  during reset. Synchronous active-high reset; the frame RAM is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_reply_frame_parser_unit (
   input  logic              clock,
   input  logic              reset,
   mrfp_req_if.sink          req_port,
   mrfp_rsp_if.source        rsp_port,
   mrfp_csr_if.sink          csr_port
);

   localparam int AW = $clog2(mrfp_pkg::FRAME_DEPTH);

   logic                 ack_mode_ff, ack_mode_in;
   mrfp_pkg::pos_type    pos_ff, pos_in;
   mrfp_pkg::crc_type    crc_ff, crc_in;
   mrfp_pkg::byte_type   trail_lo_ff, trail_lo_in;
   mrfp_pkg::byte_type   slave_addr_ff;
   logic                 rd_pend_ff, rd_pend_in;
   logic [1:0]           rd_slot_ff, rd_slot_in;
   mrfp_pkg::byte_type   hold_ff [4];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   mrfp_pkg::tenths_type rsp_angle_ff, rsp_angle_in;
   mrfp_pkg::tenths_type rsp_rate_ff, rsp_rate_in;

   logic                 accept;
   mrfp_pkg::byte_type   b;
   mrfp_pkg::pos_type    fpos, epos, enext;
   logic                 hdr_ok;
   logic                 emit;
   logic                 emit_kind;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   mrfp_pkg::byte_type   rd_data;
   mrfp_pkg::pos_type    rd_pos;

   mrfp_ram #(
      .WIDTH (8),
      .DEPTH (mrfp_pkg::FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (b),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_port.ready = ~reset & (~rsp_valid_ff | rsp_port.ready);
   assign csr_port.ready = ~reset;
   assign accept         = req_port.valid & req_port.ready;
   assign b              = req_port.rx_byte;

   assign fpos  = (pos_ff >= mrfp_pkg::FRAME_LEN) ? 4'd0 : pos_ff;
   assign epos  = (pos_ff >= mrfp_pkg::ECHO_LEN)  ? 4'd0 : pos_ff;
   assign enext = (b == mrfp_pkg::echo_byte(epos[2:0])) ? epos + 4'd1 : 4'd0;
   assign rd_pos = fpos - mrfp_pkg::PAYLOAD_LAG;

   always_comb begin
      case (fpos)
         4'd0:    hdr_ok = (b == slave_addr_ff);
         4'd1:    hdr_ok = (b == mrfp_pkg::HDR_FUNC);
         4'd2:    hdr_ok = (b == mrfp_pkg::HDR_COUNT);
         default: hdr_ok = 1'b1;
      endcase
   end

   always_comb begin
      ack_mode_in = ack_mode_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      trail_lo_in = trail_lo_ff;
      rd_pend_in  = 1'b0;
      rd_slot_in  = rd_slot_ff;
      wr_en       = 1'b0;
      wr_addr     = fpos[AW-1:0];
      rd_en       = 1'b0;
      rd_addr     = rd_pos[AW-1:0];
      emit        = 1'b0;
      emit_kind   = mrfp_pkg::KIND_DATA;
      if (accept) begin
         case (req_port.command)
            mrfp_pkg::CMD_CLEAR_SENT: begin
               ack_mode_in = 1'b1;
               pos_in      = 4'd0;
               crc_in      = mrfp_pkg::CRC_INIT;
            end
            mrfp_pkg::CMD_CLEAR_TIMEOUT: begin
               ack_mode_in = 1'b0;
               pos_in      = 4'd0;
               crc_in      = mrfp_pkg::CRC_INIT;
            end
            mrfp_pkg::CMD_BYTE: begin
               if (ack_mode_ff) begin
                  if (enext == mrfp_pkg::ECHO_LEN) begin
                     ack_mode_in = 1'b0;
                     pos_in      = 4'd0;
                     crc_in      = mrfp_pkg::CRC_INIT;
                     emit        = 1'b1;
                     emit_kind   = mrfp_pkg::KIND_ACK;
                  end else begin
                     pos_in = enext;
                  end
               end else if (!hdr_ok) begin
                  pos_in = 4'd0;
                  crc_in = mrfp_pkg::CRC_INIT;
               end else begin
                  wr_en  = 1'b1;
                  pos_in = fpos + 4'd1;
                  if (fpos < mrfp_pkg::CRC_LEN) begin
                     crc_in = mrfp_pkg::crc_feed(crc_ff, b);
                  end
                  if (fpos == mrfp_pkg::TRAIL_LO_POS) begin
                     trail_lo_in = b;
                  end
                  // fetch payload byte fpos-4 while later bytes stream in
                  if (fpos >= mrfp_pkg::PAYLOAD_LO && fpos <= mrfp_pkg::PAYLOAD_HI) begin
                     rd_en      = 1'b1;
                     rd_pend_in = 1'b1;
                     rd_slot_in = fpos[1:0] - 2'd3;
                  end
                  if (fpos == mrfp_pkg::FRAME_LEN - 4'd1) begin
                     pos_in = 4'd0;
                     crc_in = mrfp_pkg::CRC_INIT;
                     emit   = ({b, trail_lo_ff} == crc_ff);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_port.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_rate_in  = rsp_rate_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         if (emit_kind == mrfp_pkg::KIND_ACK) begin
            rsp_angle_in = '0;
            rsp_rate_in  = '0;
         end else begin
            rsp_angle_in = {hold_ff[0], hold_ff[1]};
            rsp_rate_in  = {hold_ff[2], hold_ff[3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_mode_ff   <= 1'b0;
         pos_ff        <= 4'd0;
         crc_ff        <= mrfp_pkg::CRC_INIT;
         slave_addr_ff <= 8'd8;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ack_mode_ff  <= ack_mode_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid) begin
            slave_addr_ff <= csr_port.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      trail_lo_ff  <= trail_lo_in;
      rd_slot_ff   <= rd_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_rate_ff  <= rsp_rate_in;
      if (rd_pend_ff) begin
         hold_ff[rd_slot_ff] <= rd_data;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.result_kind  = rsp_kind_ff;
   assign rsp_port.angle_tenths = rsp_angle_ff;
   assign rsp_port.rate_tenths  = rsp_rate_ff;

endmodule

>>> hdl/mrfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_checker
// Port-level checks for the reply frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module mrfp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input mrfp_pkg::command_type req_command,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_kind,
   input mrfp_pkg::tenths_type  rsp_angle,
   input mrfp_pkg::tenths_type  rsp_rate
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_angle) && $stable(rsp_rate))
      else $error("stalled result changed");

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mrfp_pkg::KIND_ACK |-> rsp_angle == 0 && rsp_rate == 0)
      else $error("ack result carries nonzero payload");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_command == mrfp_pkg::CMD_BYTE))
      else $error("result without a received byte word");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind modbus_rtu_reply_frame_parser_unit mrfp_checker u_mrfp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .req_command (req_port.command),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_kind    (rsp_port.result_kind),
   .rsp_angle   (rsp_port.angle_tenths),
   .rsp_rate    (rsp_port.rate_tenths)
);
